// ===== src/gregorian_date_arithmetic_top_assert.svh =====
// Assertion macros shared by the date arithmetic modules.
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GDA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gda assertion failed");
`define GDA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gda assertion failed");
`else
`define GDA_ASSERT_IMP(name, clk, rst, ante, cons)
`define GDA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== src/gda_pkg.sv =====
// Shared types, constants and calendar tables for the date arithmetic block.
`default_nettype none
package gda_pkg;

  localparam int MAX_YEAR_DEF = 9999;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 21;
  localparam int COUNT_W  = 23;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam int DAYS_400Y = 146097;
  localparam int COUNT_MAX = 4194303;
  localparam int COUNT_MIN = -4194304;

  // Divide by 100 through a reciprocal: exact for operands below 199000.
  localparam int DIV_X_W  = 15;
  localparam int DIV_Q_W  = 9;
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_W-1:0] RECIP100 = 18'd167773;

  localparam int CENT_W = 7;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_Y,
    DP_LEAP,
    DP_DIV_C,
    DP_SUM1,
    DP_SUM2,
    DP_FS_INIT,
    DP_FS_400,
    DP_FS_YR,
    DP_FS_MO,
    DP_OUT_OK,
    DP_OUT_BAD,
    DP_OUT_RANGE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic date_ok;
    logic r_neg;
    logic ge_400;
    logic ge_yr;
    logic ge_mo;
    logic yr_over;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LEAP,
    S_CHECK,
    S_SUM1,
    S_SUM2,
    S_DIFF,
    S_FS_INIT,
    S_FS_400,
    S_FS_YR,
    S_FS_MO,
    S_DONE
  } gda_state_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m, common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/gda_ctrl.sv =====
// Sequencer for the date arithmetic datapath.
`default_nettype none
`include "gregorian_date_arithmetic_top_assert.svh"
module gda_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  output gda_pkg::dp_cmd_t        cmd,
  input  wire gda_pkg::dp_stat_t  stat
);
  import gda_pkg::*;

  gda_state_t state, state_next;
  logic       sel_b, sel_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_b <= 1'b0;
    end else begin
      state <= state_next;
      sel_b <= sel_b_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_b_next = sel_b;
    cmd.op     = DP_NOP;
    cmd.sel_b  = sel_b;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op     = DP_LOAD;
          sel_b_next = 1'b0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op     = DP_DIV_Y;
        state_next = S_LEAP;
      end
      S_LEAP: begin
        cmd.op     = DP_LEAP;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.date_ok) begin
          cmd.op     = DP_OUT_BAD;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_DIV_C;
          state_next = S_SUM1;
        end
      end
      S_SUM1: begin
        cmd.op     = DP_SUM1;
        state_next = S_SUM2;
      end
      S_SUM2: begin
        cmd.op = DP_SUM2;
        if (sel_b) begin
          state_next = S_DIFF;
        end else if (stat.func) begin
          sel_b_next = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_FS_INIT;
        end
      end
      S_DIFF: begin
        cmd.op     = DP_OUT_OK;
        state_next = S_DONE;
      end
      S_FS_INIT: begin
        cmd.op     = DP_FS_INIT;
        state_next = S_FS_400;
      end
      S_FS_400: begin
        if (stat.r_neg) begin
          cmd.op     = DP_OUT_RANGE;
          state_next = S_DONE;
        end else if (stat.ge_400) begin
          cmd.op = DP_FS_400;
        end else begin
          state_next = S_FS_YR;
        end
      end
      S_FS_YR: begin
        if (stat.ge_yr) begin
          cmd.op = DP_FS_YR;
        end else begin
          state_next = S_FS_MO;
        end
      end
      S_FS_MO: begin
        if (stat.ge_mo) begin
          cmd.op = DP_FS_MO;
        end else if (stat.yr_over) begin
          cmd.op     = DP_OUT_RANGE;
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_OUT_OK;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `GDA_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `GDA_ASSERT_NEXT(a_done_then_idle, clk, rst, done, !busy)
  `GDA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule
`default_nettype wire

// ===== src/gda_dp.sv =====
// Datapath: date validation, day serial numbers, serial to date, results.
`default_nettype none
`include "gregorian_date_arithmetic_top_assert.svh"
module gda_dp #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire gda_pkg::dp_cmd_t                      cmd,
  output gda_pkg::dp_stat_t                          stat,
  input  wire logic                                  func,
  input  wire logic        [gda_pkg::YEAR_W-1:0]     year,
  input  wire logic        [gda_pkg::MONTH_W-1:0]    month,
  input  wire logic        [gda_pkg::DAY_W-1:0]      day,
  input  wire logic signed [gda_pkg::OFFSET_W-1:0]   offset,
  input  wire logic        [gda_pkg::YEAR_W-1:0]     other_year,
  input  wire logic        [gda_pkg::MONTH_W-1:0]    other_month,
  input  wire logic        [gda_pkg::DAY_W-1:0]      other_day,
  output logic             [gda_pkg::STATUS_W-1:0]   status,
  output logic             [gda_pkg::YEAR_W-1:0]     res_year,
  output logic             [gda_pkg::MONTH_W-1:0]    res_month,
  output logic             [gda_pkg::DAY_W-1:0]      res_day,
  output logic signed      [gda_pkg::COUNT_W-1:0]    day_count,
  output logic                                       is_equal,
  output logic                                       is_less
);
  import gda_pkg::*;

  // Serial day numbers reach (MAX_YEAR+1) years plus the largest offset; one sign bit.
  localparam int SER_MAX = (MAX_YEAR + 1) * 366 + (1 << (OFFSET_W - 1));
  localparam int SER_W   = $clog2(SER_MAX + 1) + 1;
  localparam int YR_W    = SER_W - 8;
  localparam int DW      = (SER_W > COUNT_W + 1) ? SER_W : COUNT_W + 1;

  function automatic logic [DIV_Q_W-1:0] div100(input logic [DIV_X_W-1:0] x);
    logic [DIV_X_W+RECIP_W-1:0] p;
    p = x * RECIP100;
    return p[RECIP_SH +: DIV_Q_W];
  endfunction

  // Captured transaction
  logic                       func_r;
  logic [YEAR_W-1:0]          y1_r, y2_r;
  logic [MONTH_W-1:0]         m1_r, m2_r;
  logic [DAY_W-1:0]           d1_r, d2_r;
  logic signed [OFFSET_W-1:0] off_r;

  // Working registers
  logic [DIV_Q_W-1:0]      qa, qb;
  logic                    leap_r;
  logic [SER_W-1:0]        acc, s_a, s_b;
  logic signed [SER_W-1:0] r;
  logic [YR_W-1:0]         yr;
  logic [CENT_W-1:0]       c100;
  logic [1:0]              cent;
  logic [MONTH_W-1:0]      mo;

  logic [YEAR_W-1:0]       y_sel;
  logic [MONTH_W-1:0]      m_sel;
  logic [DAY_W-1:0]        d_sel;
  logic [DIV_X_W-1:0]      div_x;
  logic [DIV_Q_W-1:0]      div_q;
  logic                    leap_y;
  logic                    leap_i;
  logic [SER_W-1:0]        ylen;
  logic [DAY_W-1:0]        mlen;
  logic signed [DW-1:0]    diff_w;
  logic [COUNT_W-1:0]      count_sat;

  assign y_sel = cmd.sel_b ? y2_r : y1_r;
  assign m_sel = cmd.sel_b ? m2_r : m1_r;
  assign d_sel = cmd.sel_b ? d2_r : d1_r;

  // One shared divide-by-100 unit: y/100, (y+99)/100, ((y+399)/4)/100 = (y+399)/400
  always_comb begin
    unique case (cmd.op)
      DP_LEAP: div_x = DIV_X_W'(y_sel) + DIV_X_W'(99);
      DP_DIV_C: div_x = (DIV_X_W'(y_sel) + DIV_X_W'(399)) >> 2;
      default: div_x = DIV_X_W'(y_sel);
    endcase
  end
  assign div_q = div100(div_x);

  // qa holds y/100 while the leap op runs
  assign leap_y = (y_sel[1:0] == 2'b00) &&
                  (((DIV_X_W'(qa) * DIV_X_W'(100)) != DIV_X_W'(y_sel)) || (qa[1:0] == 2'b00));

  // Year counter starts on a multiple of 400: c100/cent track year mod 400
  assign leap_i = (yr[1:0] == 2'b00) && ((c100 != '0) || (cent == 2'd0));
  assign ylen   = leap_i ? SER_W'(366) : SER_W'(365);
  assign mlen   = month_days(mo, leap_i);

  assign stat.func    = func_r;
  assign stat.date_ok = (int'(y_sel) <= MAX_YEAR) &&
                        (m_sel >= MONTH_W'(1)) && (m_sel <= MONTH_W'(12)) &&
                        (d_sel != '0) && (d_sel <= month_days(m_sel, leap_r));
  assign stat.r_neg   = r[SER_W-1];
  assign stat.ge_400  = r >= SER_W'(DAYS_400Y);
  assign stat.ge_yr   = r >= $signed(ylen);
  assign stat.ge_mo   = r >= $signed(SER_W'(mlen));
  assign stat.yr_over = int'(yr) > MAX_YEAR;

  assign diff_w = $signed(DW'(s_a)) - $signed(DW'(s_b));

  always_comb begin
    if (diff_w > $signed(DW'(COUNT_MAX))) begin
      count_sat = COUNT_W'(COUNT_MAX);
    end else if (diff_w < $signed(DW'(COUNT_MIN))) begin
      count_sat = COUNT_W'(COUNT_MIN);
    end else begin
      count_sat = diff_w[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        func_r <= func;
        y1_r   <= year;
        m1_r   <= month;
        d1_r   <= day;
        off_r  <= offset;
        y2_r   <= other_year;
        m2_r   <= other_month;
        d2_r   <= other_day;
      end
      DP_DIV_Y: begin
        qa <= div_q;
      end
      DP_LEAP: begin
        leap_r <= leap_y;
        qa     <= div_q;
      end
      DP_DIV_C: begin
        qb <= div_q;
      end
      DP_SUM1: begin
        acc <= SER_W'(y_sel) * SER_W'(365)
             + SER_W'((DIV_X_W'(y_sel) + DIV_X_W'(3)) >> 2)
             - SER_W'(qa);
      end
      DP_SUM2: begin
        if (cmd.sel_b) begin
          s_b <= acc + SER_W'(qb) + SER_W'(days_before(m_sel))
               + SER_W'(leap_r && (m_sel > MONTH_W'(2))) + SER_W'(d_sel) - SER_W'(1);
        end else begin
          s_a <= acc + SER_W'(qb) + SER_W'(days_before(m_sel))
               + SER_W'(leap_r && (m_sel > MONTH_W'(2))) + SER_W'(d_sel) - SER_W'(1);
        end
      end
      DP_FS_INIT: begin
        r    <= $signed(s_a) + SER_W'(off_r);
        yr   <= '0;
        c100 <= '0;
        cent <= '0;
        mo   <= MONTH_W'(1);
      end
      DP_FS_400: begin
        r  <= r - SER_W'(DAYS_400Y);
        yr <= yr + YR_W'(400);
      end
      DP_FS_YR: begin
        r  <= r - $signed(ylen);
        yr <= yr + YR_W'(1);
        if (c100 == CENT_W'(99)) begin
          c100 <= '0;
          cent <= cent + 2'd1;
        end else begin
          c100 <= c100 + CENT_W'(1);
        end
      end
      DP_FS_MO: begin
        r  <= r - $signed(SER_W'(mlen));
        mo <= mo + MONTH_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= ST_OK;
      res_year  <= '0;
      res_month <= '0;
      res_day   <= '0;
      day_count <= '0;
      is_equal  <= 1'b0;
      is_less   <= 1'b0;
    end else begin
      unique case (cmd.op) inside
        DP_OUT_OK: begin
          status <= ST_OK;
          if (!func_r) begin
            res_year  <= yr[YEAR_W-1:0];
            res_month <= mo;
            res_day   <= r[DAY_W-1:0] + DAY_W'(1);
            day_count <= '0;
            is_equal  <= 1'b0;
            is_less   <= 1'b0;
          end else begin
            res_year  <= '0;
            res_month <= '0;
            res_day   <= '0;
            day_count <= count_sat;
            is_equal  <= s_a == s_b;
            is_less   <= s_a < s_b;
          end
        end
        DP_OUT_BAD, DP_OUT_RANGE: begin
          status    <= (cmd.op == DP_OUT_BAD) ? ST_BAD_DATE : ST_RANGE;
          res_year  <= '0;
          res_month <= '0;
          res_day   <= '0;
          day_count <= '0;
          is_equal  <= 1'b0;
          is_less   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  `GDA_ASSERT_NEXT(a_month_ok, clk, rst, cmd.op == DP_OUT_OK && !func_r, res_month >= MONTH_W'(1) && res_month <= MONTH_W'(12))
  `GDA_ASSERT_IMP(a_rem_nonneg, clk, rst, cmd.op == DP_FS_YR || cmd.op == DP_FS_MO, !r[SER_W-1])
  `GDA_ASSERT_IMP(a_flags_excl, clk, rst, is_equal, !is_less)

endmodule
`default_nettype wire

// ===== src/gregorian_date_arithmetic_top.sv =====
// Top level of the Gregorian date add-days and day-difference block.
//
// Usage: one command transaction at a time. Drive func and the date fields,
// raise start; the transaction is taken at the rising edge where start is
// high and busy is low. busy stays high until the result is delivered.
//   func 0: first date moved by the signed offset -> res_year/month/day.
//   func 1: day_count = first date minus second date, is_equal, is_less.
// status 0 ok, 1 invalid input date, 2 shifted result out of year range;
// on a nonzero status every other result field is zero.
// The result appears for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle. Outputs hold between.
// After accept, an invalid first date ends the transaction early. func 1
// converts both dates and subtracts. func 0 converts the first date, then
// walks the result's 400-year blocks (at most 32), remaining years (at most
// 399) and months (at most 11) at the default MAX_YEAR. The next start is
// taken the cycle after done. The year and month walk of the serial-to-date
// conversion sets the func 0 run time.
// Reset (rst, synchronous) returns the sequencer to idle and clears results.
`default_nettype none
module gregorian_date_arithmetic_top #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  output logic                                       done,
  input  wire logic                                  func,
  input  wire logic        [gda_pkg::YEAR_W-1:0]     year,
  input  wire logic        [gda_pkg::MONTH_W-1:0]    month,
  input  wire logic        [gda_pkg::DAY_W-1:0]      day,
  input  wire logic signed [gda_pkg::OFFSET_W-1:0]   offset,
  input  wire logic        [gda_pkg::YEAR_W-1:0]     other_year,
  input  wire logic        [gda_pkg::MONTH_W-1:0]    other_month,
  input  wire logic        [gda_pkg::DAY_W-1:0]      other_day,
  output logic             [gda_pkg::STATUS_W-1:0]   status,
  output logic             [gda_pkg::YEAR_W-1:0]     res_year,
  output logic             [gda_pkg::MONTH_W-1:0]    res_month,
  output logic             [gda_pkg::DAY_W-1:0]      res_day,
  output logic signed      [gda_pkg::COUNT_W-1:0]    day_count,
  output logic                                       is_equal,
  output logic                                       is_less
);
  import gda_pkg::*;

  // Command from the sequencer, status back from the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  gda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  gda_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .year        (year),
    .month       (month),
    .day         (day),
    .offset      (offset),
    .other_year  (other_year),
    .other_month (other_month),
    .other_day   (other_day),
    .status      (status),
    .res_year    (res_year),
    .res_month   (res_month),
    .res_day     (res_day),
    .day_count   (day_count),
    .is_equal    (is_equal),
    .is_less     (is_less)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_gregorian_date_arithmetic_top.sv =====
// Testbench for the Gregorian date shift and day-difference block.
module tb_gregorian_date_arithmetic_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  // Operation codes carried on the func port.
  localparam logic OP_SHIFT = 1'b0;
  localparam logic OP_DIFF  = 1'b1;

  localparam int CAL_MAX_YEAR = MAX_YEAR_DEF;
  localparam int OFS_MAX      = 2**(OFFSET_W-1) - 1;
  localparam int OFS_MIN      = -(2**(OFFSET_W-1));
  localparam int YEAR_FIELD_MAX = 2**YEAR_W - 1;

  // Slowest legal run: ~625 transactions, each with at worst a full year and
  // month walk plus a sender gap. Several times that, still bounded.
  localparam int LIMIT_CYCLES = 1_500_000;
  // Covers the longest func 0 latency; used as the quiet tail at the end.
  localparam int TAIL_CYCLES  = 500;

  // One command transaction, as driven on the ports.
  typedef struct packed {
    logic                func;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [OFFSET_W-1:0] offset;
    logic [YEAR_W-1:0]   other_year;
    logic [MONTH_W-1:0]  other_month;
    logic [DAY_W-1:0]    other_day;
  } date_req_t;

  // One result, as it appears while done is high.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   res_year;
    logic [MONTH_W-1:0]  res_month;
    logic [DAY_W-1:0]    res_day;
    logic [COUNT_W-1:0]  day_count;
    logic                is_equal;
    logic                is_less;
  } date_res_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic func;
  logic [YEAR_W-1:0]          year;
  logic [MONTH_W-1:0]         month;
  logic [DAY_W-1:0]           day;
  logic signed [OFFSET_W-1:0] offset;
  logic [YEAR_W-1:0]          other_year;
  logic [MONTH_W-1:0]         other_month;
  logic [DAY_W-1:0]           other_day;
  logic [STATUS_W-1:0]        status;
  logic [YEAR_W-1:0]          res_year;
  logic [MONTH_W-1:0]         res_month;
  logic [DAY_W-1:0]           res_day;
  logic signed [COUNT_W-1:0]  day_count;
  logic                       is_equal;
  logic                       is_less;

  // Results owed by the block, oldest first.
  date_res_t owed_results [$];
  date_res_t head;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;   // chance in 100 that the sender idles a cycle

  // Years that sit on leap-rule or range boundaries, plus bit-13 crossings.
  int notable_years [16] = '{0, 1, 4, 99, 100, 399, 400, 1600, 1700, 1900,
                             2000, 2100, 2400, 8191, 8192, 9999};

  gregorian_date_arithmetic_top #(
    .MAX_YEAR(CAL_MAX_YEAR)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .func        (func),
    .year        (year),
    .month       (month),
    .day         (day),
    .offset      (offset),
    .other_year  (other_year),
    .other_month (other_month),
    .other_day   (other_day),
    .status      (status),
    .res_year    (res_year),
    .res_month   (res_month),
    .res_day     (res_day),
    .day_count   (day_count),
    .is_equal    (is_equal),
    .is_less     (is_less)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  // Gregorian rule; year 0 counts as a leap year.
  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // m in 1..12 only.
  function automatic int month_length(int y, int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_valid(int y, int m, int d);
    if (y > CAL_MAX_YEAR || m < 1 || m > 12 || d < 1)
      return 1'b0;
    return d <= month_length(y, m);
  endfunction

  // Days since 0000-01-01 of a valid date. The year terms count the leap
  // years strictly before y.
  function automatic int day_number(int y, int m, int d);
    int n;
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int k = 1; k < m; k++)
      n += month_length(y, k);
    return n + d - 1;
  endfunction

  // Inverse of day_number for n >= 0: whole 400-year cycles first, then
  // single years, then months.
  function automatic void day_to_date(int n, output int y, output int m, output int d);
    int r;
    y = (n / DAYS_400Y) * 400;
    r = n % DAYS_400Y;
    m = 1;
    while (r >= (leap_year(y) ? 366 : 365)) begin
      r -= leap_year(y) ? 366 : 365;
      y++;
    end
    while (r >= month_length(y, m)) begin
      r -= month_length(y, m);
      m++;
    end
    d = r + 1;
  endfunction

  // What the block must answer for one transaction. Every field that does
  // not belong to the operation, or to a nonzero status, stays zero.
  function automatic date_res_t calc_date_result(date_req_t q);
    date_res_t r;
    int        n, y, m, d, a, b;
    int        y1, m1, d1, y2, m2, d2;
    r  = '0;
    y1 = int'(q.year);
    m1 = int'(q.month);
    d1 = int'(q.day);
    y2 = int'(q.other_year);
    m2 = int'(q.other_month);
    d2 = int'(q.other_day);
    if (q.func == OP_SHIFT) begin
      if (!date_valid(y1, m1, d1)) begin
        r.status = ST_BAD_DATE;
      end else begin
        n = day_number(y1, m1, d1) + int'($signed(q.offset));
        if (n < 0) begin
          r.status = ST_RANGE;
        end else begin
          day_to_date(n, y, m, d);
          if (y > CAL_MAX_YEAR) begin
            r.status = ST_RANGE;
          end else begin
            r.status    = ST_OK;
            r.res_year  = y[YEAR_W-1:0];
            r.res_month = m[MONTH_W-1:0];
            r.res_day   = d[DAY_W-1:0];
          end
        end
      end
    end else begin
      if (!date_valid(y1, m1, d1) || !date_valid(y2, m2, d2)) begin
        r.status = ST_BAD_DATE;
      end else begin
        a = day_number(y1, m1, d1);
        b = day_number(y2, m2, d2);
        n = a - b;
        // Only reachable with a much larger year range.
        if (n > COUNT_MAX) n = COUNT_MAX;
        if (n < COUNT_MIN) n = COUNT_MIN;
        r.status    = ST_OK;
        r.day_count = n[COUNT_W-1:0];
        r.is_equal  = (a == b);
        r.is_less   = (a < b);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  // Mostly valid dates, leaning on month ends and boundary years; roughly
  // one in eight is malformed in month, day or year.
  function automatic void random_date(output logic [YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
    int yy, mm, len, roll;
    yy   = ($urandom_range(3) == 0) ? notable_years[$urandom_range(15)]
                                    : int'($urandom_range(CAL_MAX_YEAR));
    mm   = $urandom_range(12, 1);
    len  = month_length(yy, mm);
    roll = $urandom_range(99);
    y = yy[YEAR_W-1:0];
    m = mm[MONTH_W-1:0];
    if (roll < 4) begin
      // month 0 or 13..15
      m = $urandom_range(1) ? '0 : MONTH_W'($urandom_range(15, 13));
      d = DAY_W'($urandom_range(31, 1));
    end else if (roll < 7) begin
      d = '0;
    end else if (roll < 10) begin
      // day past the end of its month
      d = (len < 31) ? DAY_W'($urandom_range(31, len + 1)) : '0;
    end else if (roll < 12) begin
      y = YEAR_W'($urandom_range(YEAR_FIELD_MAX, CAL_MAX_YEAR + 1));
      d = DAY_W'($urandom_range(len, 1));
    end else if (roll < 40) begin
      d = $urandom_range(1) ? DAY_W'(1) : len[DAY_W-1:0];
    end else begin
      d = DAY_W'($urandom_range(len, 1));
    end
  endfunction

  // Offsets: short hops, long hops, the field extremes, landings just
  // around either end of the year range, and raw random bits.
  function automatic logic [OFFSET_W-1:0] random_offset(int base_no);
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = int'($urandom_range(800)) - 400;
      3, 4:    v = int'($urandom_range(80000)) - 40000;
      5:       v = $urandom_range(1) ? OFS_MAX : OFS_MIN;
      6:       v = day_number(CAL_MAX_YEAR, 12, 31) - base_no + int'($urandom_range(4)) - 2;
      7:       v = -base_no + int'($urandom_range(4)) - 2;
      default: v = int'($urandom() >> (32 - OFFSET_W)) + OFS_MIN;
    endcase
    if (v > OFS_MAX) v = OFS_MAX;
    if (v < OFS_MIN) v = OFS_MIN;
    return v[OFFSET_W-1:0];
  endfunction

  function automatic date_req_t shift_req(int y, int m, int d, int ofs);
    date_req_t q;
    q        = '0;
    q.func   = OP_SHIFT;
    q.year   = y[YEAR_W-1:0];
    q.month  = m[MONTH_W-1:0];
    q.day    = d[DAY_W-1:0];
    q.offset = ofs[OFFSET_W-1:0];
    return q;
  endfunction

  function automatic date_req_t diff_req(int y, int m, int d, int y2, int m2, int d2);
    date_req_t q;
    q             = '0;
    q.func        = OP_DIFF;
    q.year        = y[YEAR_W-1:0];
    q.month       = m[MONTH_W-1:0];
    q.day         = d[DAY_W-1:0];
    q.other_year  = y2[YEAR_W-1:0];
    q.other_month = m2[MONTH_W-1:0];
    q.other_day   = d2[DAY_W-1:0];
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Hands one transaction to the block. Inputs move only at falling edges.
  // busy is stable at a falling edge and holds until the next rising edge,
  // so busy low here with start high means the next rising edge takes it;
  // the owed result is queued at that point, before the accepting edge.
  // start is left high on return: the next call or idle cycle sets it once.
  task automatic send_request(date_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    func        <= q.func;
    year        <= q.year;
    month       <= q.month;
    day         <= q.day;
    offset      <= q.offset;
    other_year  <= q.other_year;
    other_month <= q.other_month;
    other_day   <= q.other_day;
    while (busy) @(negedge clk);
    owed_results.push_back(calc_date_result(q));
    @(posedge clk);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Shifts across month, year and century edges, the leap-rule cases, the
  // extreme offsets, and both ends of the year range.
  task automatic test_shift_edges();
    send_request(shift_req(0, 1, 1, 0));
    send_request(shift_req(0, 1, 1, -1));             // before day zero
    send_request(shift_req(CAL_MAX_YEAR, 12, 31, 1)); // past the last year
    send_request(shift_req(CAL_MAX_YEAR, 12, 31, OFS_MIN));
    send_request(shift_req(0, 1, 1, OFS_MAX));
    send_request(shift_req(2000, 2, 28, 1));          // 400 rule: leap
    send_request(shift_req(1900, 2, 28, 1));          // 100 rule: no leap
    send_request(shift_req(2100, 3, 1, -1));
    send_request(shift_req(2023, 12, 31, 1));
    send_request(shift_req(400, 2, 29, DAYS_400Y));   // one full cycle on
    send_request(shift_req(CAL_MAX_YEAR, 1, 1, 364));
    wait_for_results();
  endtask

  // Equal, earlier and later first dates, the widest span both ways, and
  // February across leap and non-leap centuries.
  task automatic test_day_difference();
    send_request(diff_req(2024, 3, 15, 2024, 3, 15));
    send_request(diff_req(0, 1, 1, CAL_MAX_YEAR, 12, 31));
    send_request(diff_req(CAL_MAX_YEAR, 12, 31, 0, 1, 1));
    send_request(diff_req(2000, 3, 1, 2000, 2, 28));
    send_request(diff_req(1900, 3, 1, 1900, 2, 28));
    wait_for_results();
  endtask

  // Malformed dates on either side; func 1 must check the second date too.
  task automatic test_invalid_dates();
    send_request(shift_req(2020, 0, 10, 5));
    send_request(shift_req(2020, 15, 31, 5));
    send_request(shift_req(2023, 4, 31, 1));
    send_request(shift_req(1900, 2, 29, 1));
    send_request(shift_req(YEAR_FIELD_MAX, 12, 31, OFS_MIN));
    send_request(shift_req(2020, 6, 0, 1));
    send_request(diff_req(2020, 6, 1, 2020, 13, 1));
    send_request(diff_req(2020, 6, 1, 2023, 2, 29));
    send_request(diff_req(CAL_MAX_YEAR + 1, 1, 1, 2020, 1, 1));
    wait_for_results();
  endtask

  // Random mix of both operations. Fields that the operation ignores get
  // raw random bits. For differences the second date is often equal to or
  // close to the first, so the flags and small counts get exercised.
  task automatic test_random_mix(int count, int gap);
    date_req_t q;
    int        n, y, m, d, roll;
    idle_pct = gap;
    repeat (count) begin
      q      = '0;
      q.func = 1'($urandom_range(1));
      random_date(q.year, q.month, q.day);
      n = date_valid(int'(q.year), int'(q.month), int'(q.day))
          ? day_number(int'(q.year), int'(q.month), int'(q.day)) : -1;
      if (q.func == OP_SHIFT) begin
        q.offset      = random_offset((n < 0) ? 0 : n);
        q.other_year  = YEAR_W'($urandom());
        q.other_month = MONTH_W'($urandom());
        q.other_day   = DAY_W'($urandom());
      end else begin
        q.offset = OFFSET_W'($urandom());
        roll     = $urandom_range(99);
        if (roll < 15) begin
          q.other_year  = q.year;
          q.other_month = q.month;
          q.other_day   = q.day;
        end else if (roll < 40 && n >= 0) begin
          n = n + int'($urandom_range(120)) - 60;
          if (n < 0) n = 0;
          day_to_date(n, y, m, d);
          if (y > CAL_MAX_YEAR) begin
            y = CAL_MAX_YEAR;
            m = 12;
            d = 31;
          end
          q.other_year  = y[YEAR_W-1:0];
          q.other_month = m[MONTH_W-1:0];
          q.other_day   = d[DAY_W-1:0];
        end else begin
          random_date(q.other_year, q.other_month, q.other_day);
        end
      end
      send_request(q);
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // done marks one result cycle; the result is taken at the rising edge
  // that closes it. Outputs are read here before that edge's updates land.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        head = owed_results.pop_front();
        check_field("status",    32'(head.status),    32'(status));
        check_field("res_year",  32'(head.res_year),  32'(res_year));
        check_field("res_month", 32'(head.res_month), 32'(res_month));
        check_field("res_day",   32'(head.res_day),   32'(res_day));
        check_field("day_count", 32'($signed(head.day_count)), 32'(day_count));
        check_field("is_equal",  32'(head.is_equal),  32'(is_equal));
        check_field("is_less",   32'(head.is_less),   32'(is_less));
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = OP_SHIFT;
    year        = '0;
    month       = '0;
    day         = '0;
    offset      = '0;
    other_year  = '0;
    other_month = '0;
    other_day   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed cases with a light sender gap.
    idle_pct = 22;
    test_shift_edges();
    test_day_difference();
    test_invalid_dates();

    // Random: light sender gaps, then heavy gaps, then back to back.
    // Each phase drains fully before the next one starts.
    test_random_mix(200, 22);
    test_random_mix(200, 84);
    test_random_mix(200, 0);

    // Quiet tail: anything arriving now is a stray result.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d transactions never returned a result", owed_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/gda_pkg.sv
src/gda_ctrl.sv
src/gda_dp.sv
src/gregorian_date_arithmetic_top.sv
tb/sv/tb_gregorian_date_arithmetic_top.sv
